/* design/tape_machine_instruction_executor_top_macros.svh */
// Assertion macros shared by the tape machine executor.
`ifndef TAPE_MACHINE_INSTRUCTION_EXECUTOR_TOP_MACROS_SVH
`define TAPE_MACHINE_INSTRUCTION_EXECUTOR_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TME_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define TME_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* design/tme_pkg.sv */
// Package for the tape machine executor: constants, opcodes and the command type.
package tme_pkg;

  localparam int TAPE_CELLS_DEF = 32768;
  // Signed width used for the tape address offset and bound arithmetic.
  localparam int ADDR_W = 34;

  localparam logic [3:0] OP_ADD    = 4'd1;
  localparam logic [3:0] OP_WINDOW = 4'd3;
  localparam logic [3:0] OP_OUT    = 4'd5;
  localparam logic [3:0] OP_IN     = 4'd6;
  localparam logic [3:0] OP_LOOPB  = 4'd7;
  localparam logic [3:0] OP_LOOPE  = 4'd8;
  localparam logic [3:0] OP_SET    = 4'd9;
  localparam logic [3:0] OP_COPY   = 4'd10;
  localparam logic [3:0] OP_MUL    = 4'd11;
  localparam logic [3:0] OP_SCAN   = 4'd12;
  localparam logic [3:0] OP_MOVE   = 4'd13;
  localparam logic [3:0] OP_FILL   = 4'd14;

  typedef struct packed {
    logic [3:0]         func;
    logic signed [31:0] full;
    logic signed [15:0] off;
    logic [7:0]         cnt;
    logic [7:0]         argb;
    logic               arg_m1;
    logic               back_scan;
    logic [7:0]         ch;
    logic               eof;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

endpackage

/* design/tme_if.sv */
// Handshake interfaces for the instruction and result channels.
interface tme_in_if;
  logic               valid;
  logic               ready;
  logic [3:0]         func;
  logic signed [31:0] arg_word;
  logic [7:0]         in_char;
  logic               in_eof;
  modport source (output valid, func, arg_word, in_char, in_eof, input ready);
  modport sink (input valid, func, arg_word, in_char, in_eof, output ready);
endinterface

interface tme_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] next_pc;
  logic        out_valid;
  logic [7:0]  out_char;
  logic        halted;
  logic        fault;
  modport source (output valid, next_pc, out_valid, out_char, halted, fault, input ready);
  modport sink (input valid, next_pc, out_valid, out_char, halted, fault, output ready);
endinterface

/* design/tape_machine_instruction_executor_top.sv */
// Top level of the tape machine instruction executor.
// After reset the block zeroes every cell of the tape RAM (32768 cells by default),
// and takes no instruction word during that time; the code size register may be written
// throughout. Each instruction word yields exactly one result word. A two-entry queue
// behind the instruction port lets words arrive while the executor is busy. The executor
// shares a single tape RAM with one write and one registered read port, so the cost of an
// instruction is set by its tape accesses: window, set, input, loop end and out-of-range
// cases finish in ST_EXEC, add, output, move and loop begin go on through ST_R1, copy and
// multiply-add through ST_R1 and ST_R2, a scan stays in ST_SCAN for each cell examined,
// and a fill stays in ST_FILL for each cell written. A new instruction starts once the
// previous result has been taken or is taken in the same cycle.
`include "tape_machine_instruction_executor_top_macros.svh"

module tape_machine_instruction_executor_top #(
  parameter int TAPE_CELLS = tme_pkg::TAPE_CELLS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  tme_in_if.sink      cmd,
  tme_out_if.source   res
);
  // Number of instructions in the loaded program; bounds jumps and halting.
  logic [15:0] code_size;
  // Queue head handed from the front end to the executor.
  tme_pkg::q_head_t head;
  logic pop;
  // High while the tape is being zeroed after reset.
  logic clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      code_size <= 16'd0;
    end else if (cfg_we) begin
      code_size <= cfg_wdata;
    end
  end

  tme_front u_front (
    .clk(clk), .rst(rst), .hold(clearing), .cmd(cmd), .head(head), .pop(pop)
  );

  tme_back #(.TAPE_CELLS(TAPE_CELLS)) u_back (
    .clk(clk), .rst(rst), .code_size(code_size), .head(head), .pop(pop),
    .clearing(clearing), .res(res)
  );

  // No instruction word may be taken while the tape is still being cleared.
  `TME_ASSERT_NOW(a_no_accept_clear, clearing, !cmd.ready, "word accepted during tape clear")
  // A fault always stops execution.
  `TME_ASSERT_NOW(a_fault_halts, res.valid && res.fault, res.halted, "fault without halt")
  // The byte field is zero whenever no byte is carried.
  `TME_ASSERT_NOW(a_char_zero, res.valid && !res.out_valid, res.out_char == 8'd0,
                  "stray output byte")
  // The queue is only popped when it holds an entry.
  `TME_ASSERT_NOW(a_pop_valid, pop, head.valid, "pop from empty queue")
  // Once a faulting word is taken, fault status never clears without reset.
  `TME_ASSERT_NEXT(a_fault_sticky, res.valid && res.ready && res.fault,
                   !res.valid || res.fault, "fault flag dropped")

endmodule

/* design/tme_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module tme_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* design/tme_front.sv */
// Front end: accepts instruction words, decodes operands and queues them.
module tme_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           hold,
  tme_in_if.sink         cmd,
  output tme_pkg::q_head_t head,
  input  logic           pop
);
  tme_pkg::cmd_t slot [2];
  tme_pkg::cmd_t dec;
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       push;

  always_comb begin
    dec.func      = cmd.func;
    dec.full      = cmd.arg_word;
    dec.off       = cmd.arg_word[15:0];
    dec.cnt       = cmd.arg_word[23:16];
    dec.argb      = cmd.arg_word[31:24];
    dec.arg_m1    = (cmd.arg_word[31:24] == 8'hFF);
    dec.back_scan = cmd.arg_word[31];
    dec.ch        = cmd.in_char;
    dec.eof       = cmd.in_eof;
  end

  assign cmd.ready  = (count != 2'd2) && !hold;
  assign push       = cmd.valid && cmd.ready;
  assign head.valid = (count != 2'd0);
  assign head.cmd   = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= dec;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

/* design/tme_back.sv */
// Back end: sequencer that executes queued instructions against the tape RAM.
module tme_back #(
  parameter int TAPE_CELLS = tme_pkg::TAPE_CELLS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [15:0]      code_size,
  input  tme_pkg::q_head_t head,
  output logic             pop,
  output logic             clearing,
  tme_out_if.source        res
);
  localparam int PW = $clog2(TAPE_CELLS);
  localparam int AW = tme_pkg::ADDR_W;
  localparam logic [PW-1:0] LAST = PW'(TAPE_CELLS - 1);
  localparam logic signed [AW-1:0] CELLS = AW'(TAPE_CELLS);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_EXEC  = 3'd1;
  localparam logic [2:0] ST_R1    = 3'd2;
  localparam logic [2:0] ST_R2    = 3'd3;
  localparam logic [2:0] ST_SCAN  = 3'd4;
  localparam logic [2:0] ST_FILL  = 3'd5;

  logic [2:0]    state, state_next;
  logic [PW-1:0] ptr, ptr_next, idx, idx_next, clr_cnt;
  logic [15:0]   pc, pc_next;
  logic          stopped, stopped_next, fault, fault_next;
  tme_pkg::cmd_t cur;
  logic [7:0]    d1, d1_next, remain, remain_next;
  logic [15:0]   r_pc, r_pc_next;
  logic          r_vld, r_vld_next, r_ov, r_ov_next, r_halt, r_halt_next;
  logic          r_fault, r_fault_next;
  logic [7:0]    r_ch, r_ch_next;

  logic          we;
  logic [PW-1:0] waddr, raddr;
  logic [7:0]    wdata, rdata;

  tme_pkg::cmd_t op;
  logic signed [AW-1:0] pw, dst, src, win, fend, cs;
  logic dst_ok, src_ok, win_ok, fend_ok;
  logic start, fin, ex, f_fail, f_halt;
  logic [15:0] jmp;

  tme_ram #(.WIDTH(8), .DEPTH(TAPE_CELLS)) u_tape (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign clearing      = (state == ST_CLEAR);
  assign res.valid     = r_vld;
  assign res.next_pc   = r_pc;
  assign res.out_valid = r_ov;
  assign res.out_char  = r_ch;
  assign res.halted    = r_halt;
  assign res.fault     = r_fault;

  assign start = (state == ST_EXEC) && head.valid && (!r_vld || res.ready);
  assign pop   = start;
  assign op    = (state == ST_EXEC) ? head.cmd : cur;

  always_comb begin
    pw      = AW'({1'b0, ptr});
    dst     = pw + AW'(op.off);
    src     = pw + AW'($signed(op.argb));
    win     = pw + AW'(op.full);
    fend    = dst + AW'({1'b0, op.cnt}) - AW'(1);
    cs      = AW'({1'b0, code_size});
    dst_ok  = !dst[AW-1] && (dst < CELLS);
    src_ok  = !src[AW-1] && (src < CELLS);
    win_ok  = !win[AW-1] && (win < CELLS);
    fend_ok = !fend[AW-1] && (fend < CELLS);
    if (AW'(op.full) > cs) begin
      jmp = 16'd0;
    end else if (op.full[31]) begin
      jmp = code_size;
    end else begin
      jmp = op.full[15:0];
    end
  end

  always_comb begin
    state_next   = state;
    ptr_next     = ptr;
    idx_next     = idx;
    pc_next      = pc;
    stopped_next = stopped;
    fault_next   = fault;
    d1_next      = d1;
    remain_next  = remain;
    we           = 1'b0;
    waddr        = dst[PW-1:0];
    wdata        = op.argb;
    raddr        = ptr;
    fin          = 1'b0;
    ex           = 1'b1;
    f_fail       = 1'b0;
    f_halt       = 1'b0;
    r_ov_next    = 1'b0;
    r_ch_next    = 8'd0;
    unique case (state)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_cnt;
        wdata = 8'd0;
        if (clr_cnt == LAST) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (start) begin
          if (stopped) begin
            fin = 1'b1;
            ex  = 1'b0;
          end else if (pc >= code_size) begin
            fin          = 1'b1;
            ex           = 1'b0;
            stopped_next = 1'b1;
          end else begin
            pc_next = pc + 16'd1;
            priority case (op.func)
              tme_pkg::OP_ADD, tme_pkg::OP_MUL: begin
                if (dst_ok) begin
                  raddr      = (op.func == tme_pkg::OP_MUL) ? ptr : dst[PW-1:0];
                  state_next = ST_R1;
                end else begin
                  fin    = 1'b1;
                  f_fail = 1'b1;
                end
              end
              tme_pkg::OP_WINDOW: begin
                fin = 1'b1;
                if (win_ok) begin
                  ptr_next = win[PW-1:0];
                end else begin
                  f_fail = 1'b1;
                end
              end
              tme_pkg::OP_OUT: begin
                if (op.arg_m1 || dst_ok) begin
                  raddr      = op.arg_m1 ? ptr : dst[PW-1:0];
                  state_next = ST_R1;
                end else begin
                  fin    = 1'b1;
                  f_fail = 1'b1;
                end
              end
              tme_pkg::OP_IN: begin
                fin   = 1'b1;
                wdata = op.ch;
                waddr = op.arg_m1 ? ptr : dst[PW-1:0];
                if (op.eof) begin
                  f_halt = 1'b1;
                end else if (op.arg_m1 || dst_ok) begin
                  we = 1'b1;
                end else begin
                  f_fail = 1'b1;
                end
              end
              tme_pkg::OP_LOOPB: begin
                state_next = ST_R1;
              end
              tme_pkg::OP_LOOPE: begin
                fin     = 1'b1;
                pc_next = jmp;
              end
              tme_pkg::OP_SET: begin
                fin = 1'b1;
                if (dst_ok) begin
                  we = 1'b1;
                end else begin
                  f_fail = 1'b1;
                end
              end
              tme_pkg::OP_COPY, tme_pkg::OP_MOVE: begin
                if (dst_ok && src_ok) begin
                  raddr      = src[PW-1:0];
                  state_next = ST_R1;
                end else begin
                  fin    = 1'b1;
                  f_fail = 1'b1;
                end
              end
              tme_pkg::OP_SCAN: begin
                idx_next   = ptr;
                state_next = ST_SCAN;
              end
              tme_pkg::OP_FILL: begin
                if (op.cnt == 8'd0) begin
                  fin = 1'b1;
                end else if (dst_ok && fend_ok) begin
                  idx_next    = dst[PW-1:0];
                  remain_next = op.cnt;
                  state_next  = ST_FILL;
                end else begin
                  fin    = 1'b1;
                  f_fail = 1'b1;
                end
              end
              default: begin
                fin = 1'b1;
              end
            endcase
          end
        end
      end
      ST_R1: begin
        priority case (op.func)
          tme_pkg::OP_ADD: begin
            fin   = 1'b1;
            we    = 1'b1;
            wdata = rdata + op.argb;
          end
          tme_pkg::OP_OUT: begin
            fin       = 1'b1;
            r_ov_next = 1'b1;
            r_ch_next = rdata;
          end
          tme_pkg::OP_LOOPB: begin
            fin = 1'b1;
            if (rdata == 8'd0) begin
              pc_next = jmp;
            end
          end
          tme_pkg::OP_COPY: begin
            d1_next    = rdata;
            raddr      = dst[PW-1:0];
            state_next = ST_R2;
          end
          tme_pkg::OP_MUL: begin
            d1_next    = 8'(rdata * op.argb);
            raddr      = dst[PW-1:0];
            state_next = ST_R2;
          end
          tme_pkg::OP_MOVE: begin
            fin   = 1'b1;
            we    = 1'b1;
            wdata = rdata;
          end
          default: begin
            fin = 1'b1;
          end
        endcase
      end
      ST_R2: begin
        fin   = 1'b1;
        we    = 1'b1;
        wdata = rdata + d1;
      end
      ST_SCAN: begin
        if (rdata == 8'd0) begin
          fin      = 1'b1;
          ptr_next = idx;
        end else if (op.back_scan ? (idx == '0) : (idx == LAST)) begin
          fin    = 1'b1;
          f_fail = 1'b1;
        end else begin
          idx_next = op.back_scan ? idx - PW'(1) : idx + PW'(1);
          raddr    = idx_next;
        end
      end
      ST_FILL: begin
        we          = 1'b1;
        waddr       = idx;
        idx_next    = idx + PW'(1);
        remain_next = remain - 8'd1;
        if (remain == 8'd1) begin
          fin = 1'b1;
        end
      end
      default: begin
        state_next = ST_EXEC;
      end
    endcase

    if (fin) begin
      state_next = ST_EXEC;
      if (ex) begin
        if (f_fail) begin
          fault_next = 1'b1;
        end
        if (f_fail || f_halt || (pc_next >= code_size)) begin
          stopped_next = 1'b1;
        end
      end
    end
    r_vld_next   = fin ? 1'b1 : (r_vld && !res.ready);
    r_pc_next    = pc_next;
    r_halt_next  = stopped_next;
    r_fault_next = fault_next;
  end

  always_ff @(posedge clk) begin
    idx    <= idx_next;
    d1     <= d1_next;
    remain <= remain_next;
    if (start) begin
      cur <= head.cmd;
    end
    if (fin) begin
      r_pc    <= r_pc_next;
      r_ov    <= r_ov_next;
      r_ch    <= r_ch_next;
      r_halt  <= r_halt_next;
      r_fault <= r_fault_next;
    end
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
      ptr     <= '0;
      pc      <= 16'd0;
      stopped <= 1'b0;
      fault   <= 1'b0;
      r_vld   <= 1'b0;
    end else begin
      state   <= state_next;
      clr_cnt <= clr_cnt + PW'(1);
      ptr     <= ptr_next;
      pc      <= pc_next;
      stopped <= stopped_next;
      fault   <= fault_next;
      r_vld   <= r_vld_next;
    end
  end
endmodule
